@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file of the hash table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

@@ src/rhh_pkg.sv @@
// Shared types and constants of the Robin Hood hash table.
package rhh_pkg;
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam int KEY_W      = 64;
  localparam int LEN_W      = 4;
  localparam int VAL_PORT_W = 32;
  localparam int LIMIT_W    = 7;
  localparam int OP_W       = 2;
  localparam int HASH_SHIFT = 5;

  localparam logic [31:0]        HASH_SEED   = 32'd5381;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd90;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX   = 7'd100;
endpackage

@@ src/rhh_front.sv @@
// Front end: accepts request words, normalises them and hashes the key a byte a cycle.
module rhh_front
  import rhh_pkg::*;
#(
  parameter int SLOT_W    = 10,
  parameter int KEY_BYTES = 8,
  parameter int VAL_W     = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_opcode,
  input  logic [KEY_W-1:0]      in_key_bytes,
  input  logic [LEN_W-1:0]      in_key_length,
  input  logic [VAL_PORT_W-1:0] in_new_value,
  input  logic                  clearing,
  output logic                  req_valid,
  input  logic                  req_ready,
  output logic [OP_W-1:0]       req_op,
  output logic [KEY_W-1:0]      req_key,
  output logic [LEN_W-1:0]      req_len,
  output logic [VAL_W-1:0]      req_val,
  output logic [SLOT_W-1:0]     req_home
);
  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_t;

  fstate_t           state_r;
  op_t               op_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  shift_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  left_r;
  logic [VAL_W-1:0]  val_r;
  logic [SLOT_W-1:0] hash_r;
  logic [SLOT_W-1:0] hash_nxt;
  logic [LEN_W-1:0]  len_c;
  logic [KEY_W-1:0]  key_m;
  op_t               op_c;

  always_comb begin
    if (in_key_length == '0) begin
      len_c = LEN_W'(1);
    end else if (in_key_length > LEN_W'(KEY_BYTES)) begin
      len_c = LEN_W'(KEY_BYTES);
    end else begin
      len_c = in_key_length;
    end
  end

  always_comb begin
    for (int i = 0; i < KEY_W / 8; i++) begin
      key_m[8*i +: 8] = (LEN_W'(i) < len_c) ? in_key_bytes[8*i +: 8] : 8'd0;
    end
  end

  // The spare opcode behaves as a lookup.
  always_comb begin
    unique case (in_opcode)
      OP_INSERT: op_c = OP_INSERT;
      OP_REMOVE: op_c = OP_REMOVE;
      default:   op_c = OP_LOOKUP;
    endcase
  end

  // Only the slot bits of the hash survive, so the arithmetic is kept that narrow.
  assign hash_nxt = (hash_r << HASH_SHIFT) + hash_r + SLOT_W'(shift_r[7:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid && !in_stall) begin
            op_r    <= op_c;
            key_r   <= key_m;
            shift_r <= key_m;
            len_r   <= len_c;
            left_r  <= len_c;
            val_r   <= in_new_value[VAL_W-1:0];
            hash_r  <= HASH_SEED[SLOT_W-1:0];
            state_r <= F_HASH;
          end
        end
        F_HASH: begin
          hash_r  <= hash_nxt;
          shift_r <= shift_r >> 8;
          left_r  <= left_r - LEN_W'(1);
          if (left_r == LEN_W'(1)) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (req_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != F_IDLE) || clearing;
  assign req_valid = (state_r == F_PUSH);
  assign req_op    = op_r;
  assign req_key   = key_r;
  assign req_len   = len_r;
  assign req_val   = val_r;
  assign req_home  = hash_r;
endmodule

@@ src/rhh_queue.sv @@
// Two-entry request queue between the front end and the table engine.
module rhh_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] store_r [2];
  logic             wr_r;
  logic             rd_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic             pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = store_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end
endmodule

@@ src/rhh_back.sv @@
// Table engine: slot memory, probing, Robin Hood insertion and backward-shift removal.
module rhh_back
  import rhh_pkg::*;
#(
  parameter int CAPACITY = 1024,
  parameter int SLOT_W   = 10,
  parameter int CNT_W    = 11,
  parameter int VAL_W    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [LIMIT_W-1:0]    cfg_wr_data,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  logic [OP_W-1:0]       q_op,
  input  logic [KEY_W-1:0]      q_key,
  input  logic [LEN_W-1:0]      q_len,
  input  logic [VAL_W-1:0]      q_val,
  input  logic [SLOT_W-1:0]     q_home,
  output logic                  clearing,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [VAL_PORT_W-1:0] out_read_value,
  output logic [SLOT_W-1:0]     out_slot_index,
  output logic [CNT_W-1:0]      out_entry_total
);
  localparam int PW = LIMIT_W + CNT_W;

  typedef struct packed {
    logic              occ;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [VAL_W-1:0]  val;
    logic [SLOT_W-1:0] home;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FRD, S_FCMP, S_IRD, S_ICMP, S_RRD, S_RCMP
  } bstate_t;

  entry_t mem_q [CAPACITY];
  entry_t rd_q;
  entry_t mem_wdata;
  entry_t carry;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_addr;

  bstate_t              state_r;
  op_t                  op_r;
  logic [KEY_W-1:0]     key_r;
  logic [LEN_W-1:0]     len_r;
  logic [VAL_W-1:0]     val_r;
  logic [SLOT_W-1:0]    home_r;
  logic [SLOT_W-1:0]    pos_r;
  logic [SLOT_W-1:0]    cnt_r;
  logic [SLOT_W-1:0]    placed_r;
  logic                 have_r;
  logic [SLOT_W-1:0]    longest_r;
  logic [CNT_W-1:0]     count_r;
  logic [LIMIT_W-1:0]   lim_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [VAL_PORT_W-1:0] out_value_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [CNT_W-1:0]     out_total_r;

  logic [SLOT_W-1:0]  nxt_pos;
  logic [SLOT_W-1:0]  rich_d;
  logic               hit;
  logic               stop;
  logic               full;
  logic [LIMIT_W-1:0] lim_c;
  logic [PW-1:0]      used;
  logic [PW-1:0]      allowed;

  assign nxt_pos = pos_r + SLOT_W'(1);
  assign rich_d  = pos_r - rd_q.home;
  assign hit     = rd_q.occ && (rd_q.len == len_r) && (rd_q.key == key_r);
  assign stop    = !rd_q.occ || (rd_q.home == nxt_pos);
  assign lim_c   = (lim_r > LIMIT_MAX) ? LIMIT_MAX : lim_r;
  assign used    = PW'(count_r) * PW'(LIMIT_MAX);
  assign allowed = PW'(lim_c) << SLOT_W;
  assign full    = (count_r >= CNT_W'(CAPACITY)) || (used >= allowed);

  always_comb begin
    carry.occ  = 1'b1;
    carry.key  = key_r;
    carry.len  = len_r;
    carry.val  = val_r;
    carry.home = home_r;
  end

  always_comb begin
    mem_addr  = pos_r;
    mem_we    = 1'b0;
    mem_wdata = carry;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_FCMP: begin
        if (hit && op_r == OP_INSERT) begin
          mem_we        = 1'b1;
          mem_wdata     = rd_q;
          mem_wdata.val = val_r;
        end
      end
      S_ICMP: begin
        mem_we = !rd_q.occ || (rich_d < cnt_r);
      end
      S_RRD: begin
        mem_addr = nxt_pos;
      end
      S_RCMP: begin
        mem_we    = 1'b1;
        mem_wdata = stop ? entry_t'('0) : rd_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pos_r       <= '0;
      count_r     <= '0;
      longest_r   <= '0;
      lim_r       <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lim_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          pos_r <= nxt_pos;
          if (pos_r == SLOT_W'(CAPACITY - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid && !out_valid_r) begin
            op_r    <= op_t'(q_op);
            key_r   <= q_key;
            len_r   <= q_len;
            val_r   <= q_val;
            home_r  <= q_home;
            pos_r   <= q_home;
            cnt_r   <= '0;
            state_r <= S_FRD;
          end
        end
        S_FRD: state_r <= S_FCMP;
        S_FCMP: begin
          if (hit) begin
            out_status_r <= ST_FOUND;
            out_slot_r   <= pos_r;
            out_value_r  <= (op_r == OP_INSERT) ? '0 : VAL_PORT_W'(rd_q.val);
            if (op_r == OP_REMOVE) begin
              state_r <= S_RRD;
            end else begin
              out_total_r <= count_r;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
          end else if (rd_q.occ && cnt_r != longest_r) begin
            pos_r   <= nxt_pos;
            cnt_r   <= cnt_r + SLOT_W'(1);
            state_r <= S_FRD;
          end else if (op_r == OP_INSERT && !full) begin
            pos_r   <= home_r;
            cnt_r   <= '0;
            have_r  <= 1'b0;
            state_r <= S_IRD;
          end else begin
            out_status_r <= (op_r == OP_INSERT) ? ST_FULL : ST_ABSENT;
            out_slot_r   <= '0;
            out_value_r  <= '0;
            out_total_r  <= count_r;
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_IRD: state_r <= S_ICMP;
        S_ICMP: begin
          if (!rd_q.occ) begin
            if (cnt_r > longest_r) begin
              longest_r <= cnt_r;
            end
            count_r      <= count_r + CNT_W'(1);
            out_status_r <= ST_INSERTED;
            out_slot_r   <= have_r ? placed_r : pos_r;
            out_value_r  <= '0;
            out_total_r  <= count_r + CNT_W'(1);
            out_valid_r  <= 1'b1;
            state_r      <= S_IDLE;
          end else begin
            if (rich_d < cnt_r) begin
              // The resident sits closer to home: it yields the slot and is carried on.
              if (cnt_r > longest_r) begin
                longest_r <= cnt_r;
              end
              if (!have_r) begin
                placed_r <= pos_r;
                have_r   <= 1'b1;
              end
              key_r  <= rd_q.key;
              len_r  <= rd_q.len;
              val_r  <= rd_q.val;
              home_r <= rd_q.home;
              cnt_r  <= rich_d + SLOT_W'(1);
            end else begin
              cnt_r <= cnt_r + SLOT_W'(1);
            end
            pos_r   <= nxt_pos;
            state_r <= S_IRD;
          end
        end
        S_RRD: state_r <= S_RCMP;
        S_RCMP: begin
          if (stop) begin
            count_r     <= count_r - CNT_W'(1);
            out_total_r <= count_r - CNT_W'(1);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            pos_r   <= nxt_pos;
            state_r <= S_RRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign q_ready         = (state_r == S_IDLE) && !out_valid_r;
  assign clearing        = (state_r == S_CLEAR);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_value_r;
  assign out_slot_index  = out_slot_r;
  assign out_entry_total = out_total_r;
endmodule

@@ src/robin_hood_hash_table.sv @@
// Top level of the Robin Hood hash table: front end, request queue and table engine.
//
// Requests arrive as words on the in_ channel (valid/stall) and each gives exactly one
// result word on the out_ channel, in request order. A word is taken at a clock edge
// where valid is high and stall is low; the receiver drives stall.
// The front end takes one word, then hashes the key one byte per cycle, and takes
// no new word until it has handed the request on. A two-word queue lets it run
// ahead while the engine works on an earlier request.
// The engine probes the single-port slot memory one slot at a time (address,
// then compare and write); lookups probe at most longest_probe+1 slots, insertions
// and removals walk on to the end of the displaced run.
// After reset the engine sweeps the slot memory, one slot per cycle, through all
// CAPACITY slots; in_stall stays high meanwhile. The load limit register may be
// written then.
// A result waits in the output register while out_stall is high; the engine does not
// start a new request until it has been taken, but the front end keeps filling the queue.
`include "assert_macros.svh"
module robin_hood_hash_table
  import rhh_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BYTES  = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [LIMIT_W-1:0]            cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [OP_W-1:0]               in_opcode,
  input  logic [KEY_W-1:0]              in_key_bytes,
  input  logic [LEN_W-1:0]              in_key_length,
  input  logic [VAL_PORT_W-1:0]         in_new_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [VAL_PORT_W-1:0]         out_read_value,
  output logic [$clog2(CAPACITY)-1:0]   out_slot_index,
  output logic [$clog2(CAPACITY):0]     out_entry_total
);
  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = SLOT_W + 1;
  // Results are only 32 bits wide, so stored values never need more.
  localparam int VAL_W  = (VALUE_BITS > VAL_PORT_W) ? VAL_PORT_W : VALUE_BITS;
  localparam int REQ_W  = OP_W + KEY_W + LEN_W + VAL_W + SLOT_W;

  logic              clearing;
  logic              f_valid;
  logic              f_ready;
  logic [OP_W-1:0]   f_op;
  logic [KEY_W-1:0]  f_key;
  logic [LEN_W-1:0]  f_len;
  logic [VAL_W-1:0]  f_val;
  logic [SLOT_W-1:0] f_home;
  logic              q_valid;
  logic              q_ready;
  logic [REQ_W-1:0]  q_data;

  rhh_front #(
    .SLOT_W    (SLOT_W),
    .KEY_BYTES (KEY_BYTES),
    .VAL_W     (VAL_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_key_bytes  (in_key_bytes),
    .in_key_length (in_key_length),
    .in_new_value  (in_new_value),
    .clearing      (clearing),
    .req_valid     (f_valid),
    .req_ready     (f_ready),
    .req_op        (f_op),
    .req_key       (f_key),
    .req_len       (f_len),
    .req_val       (f_val),
    .req_home      (f_home)
  );

  rhh_queue #(
    .WIDTH (REQ_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_op, f_key, f_len, f_val, f_home}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  rhh_back #(
    .CAPACITY (CAPACITY),
    .SLOT_W   (SLOT_W),
    .CNT_W    (CNT_W),
    .VAL_W    (VAL_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_op            (q_data[REQ_W-1 -: OP_W]),
    .q_key           (q_data[REQ_W-OP_W-1 -: KEY_W]),
    .q_len           (q_data[VAL_W+SLOT_W+LEN_W-1 -: LEN_W]),
    .q_val           (q_data[VAL_W+SLOT_W-1 -: VAL_W]),
    .q_home          (q_data[SLOT_W-1:0]),
    .clearing        (clearing),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_slot_index  (out_slot_index),
    .out_entry_total (out_entry_total)
  );

  // No result can appear while the slot memory is still being swept.
  `ASSERT_NEVER(a_no_result_in_clear, clearing && out_valid, "result during clearing sweep")
  // The sweep must hold the input side off.
  `ASSERT_CLK(a_stall_in_clear, clearing |-> in_stall, "input open during clearing sweep")
  // The key count can never exceed the capacity.
  `ASSERT_CLK(a_total_bound, out_valid |-> (out_entry_total <= CNT_W'(CAPACITY)), "count overflow")
  // A refused insert reports neither a slot nor a value.
  `ASSERT_CLK(a_full_clean, (out_valid && out_status == ST_FULL) |-> (out_slot_index == '0 && out_read_value == '0), "full result carries data")
endmodule

@@ tb/sv/robin_hood_hash_table_tb.sv @@
// Self-checking testbench of the Robin Hood hash table: directed table, random requests, predictor.
module robin_hood_hash_table_tb;
  import rhh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP      = 1024;
  localparam int SLOT_W   = 10;
  localparam int N_RANDOM = 1650;
  // The slowest correct run is bounded loosely: clearing sweep, then each request
  // may walk a long displaced run and wait out a long receiver stall.
  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_opcode = '0;
  logic [KEY_W-1:0] in_key_bytes = '0;
  logic [LEN_W-1:0] in_key_length = 4'd1;
  logic [VAL_PORT_W-1:0] in_new_value = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [1:0] out_status;
  logic [VAL_PORT_W-1:0] out_read_value;
  logic [SLOT_W-1:0] out_slot_index;
  logic [SLOT_W:0] out_entry_total;

  robin_hood_hash_table DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_key_bytes(in_key_bytes),
    .in_key_length(in_key_length), .in_new_value(in_new_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_read_value(out_read_value),
    .out_slot_index(out_slot_index), .out_entry_total(out_entry_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [KEY_W-1:0]      key;
    logic [LEN_W-1:0]      len;
    logic [VAL_PORT_W-1:0] val;
  } request_t;

  typedef struct packed {
    status_t               status;
    logic [VAL_PORT_W-1:0] value;
    logic [SLOT_W-1:0]     slot;
    logic [SLOT_W:0]       total;
  } reply_t;

  // Shadow copy of the table, kept in step with every accepted request word.
  logic [KEY_W-1:0]      sh_key [CAP];
  logic [LEN_W-1:0]      sh_len [CAP];
  logic [VAL_PORT_W-1:0] sh_val [CAP];
  logic                  sh_used[CAP];
  int unsigned           sh_count;
  int unsigned           sh_probe;
  int unsigned           sh_limit;

  reply_t      replies_due[$];
  int unsigned mismatches = 0;
  bit          receiver_hold = 1'b0;

  // Keys recently inserted, so that lookups and removals often hit.
  logic [KEY_W-1:0] pool_key[$];
  logic [LEN_W-1:0] pool_len[$];

  function automatic logic [SLOT_W-1:0] djb2_home(logic [KEY_W-1:0] k, int unsigned n);
    logic [31:0] h;
    h = HASH_SEED;
    for (int i = 0; i < n; i++) h = (h << HASH_SHIFT) + h + 32'(k[8*i +: 8]);
    return h[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] displacement(logic [SLOT_W-1:0] p);
    return p - djb2_home(sh_key[p], sh_len[p]);
  endfunction

  function automatic bit locate(logic [KEY_W-1:0] k, int unsigned n,
                                output logic [SLOT_W-1:0] where);
    logic [SLOT_W-1:0] p;
    p = djb2_home(k, n);
    where = '0;
    for (int i = 0; i <= sh_probe && i < CAP; i++) begin
      if (!sh_used[p]) return 1'b0;
      if (sh_len[p] == n && sh_key[p] == k) begin
        where = p;
        return 1'b1;
      end
      p = p + 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [SLOT_W-1:0] robin_place(logic [KEY_W-1:0] k, logic [LEN_W-1:0] n,
                                                    logic [VAL_PORT_W-1:0] v);
    logic [SLOT_W-1:0] p, first;
    logic [KEY_W-1:0] tk;
    logic [LEN_W-1:0] tl;
    logic [VAL_PORT_W-1:0] tv;
    int unsigned d, rd;
    bit placed;
    p = djb2_home(k, n);
    d = 0;
    first = '0;
    placed = 1'b0;
    for (int i = 0; i < CAP; i++) begin
      if (!sh_used[p]) begin
        sh_used[p] = 1'b1; sh_key[p] = k; sh_len[p] = n; sh_val[p] = v;
        if (d > sh_probe) sh_probe = d;
        if (!placed) first = p;
        break;
      end
      rd = displacement(p);
      if (rd < d) begin
        tk = sh_key[p]; tl = sh_len[p]; tv = sh_val[p];
        sh_key[p] = k; sh_len[p] = n; sh_val[p] = v;
        if (d > sh_probe) sh_probe = d;
        if (!placed) begin
          first = p;
          placed = 1'b1;
        end
        k = tk; n = tl; v = tv; d = rd;
      end
      d++;
      p = p + 1'b1;
    end
    sh_count++;
    return first;
  endfunction

  function automatic void backward_shift(logic [SLOT_W-1:0] p);
    logic [SLOT_W-1:0] q;
    sh_used[p] = 1'b0;
    for (int i = 0; i < CAP; i++) begin
      q = p + 1'b1;
      if (!sh_used[q] || displacement(q) == 0) break;
      sh_key[p] = sh_key[q]; sh_len[p] = sh_len[q]; sh_val[p] = sh_val[q];
      sh_used[p] = 1'b1;
      sh_used[q] = 1'b0;
      p = q;
    end
    if (sh_count > 0) sh_count--;
  endfunction

  // Works out the reply to one request word and updates the shadow table.
  function automatic reply_t table_reply(request_t r);
    reply_t o;
    int unsigned n, lim;
    logic [KEY_W-1:0] k;
    logic [SLOT_W-1:0] w;
    n = r.len == 0 ? 1 : (r.len > 8 ? 8 : r.len);
    k = (n == 8) ? r.key : (r.key & ((64'd1 << (8*n)) - 1));
    lim = sh_limit > 100 ? 100 : sh_limit;
    o.status = ST_ABSENT;
    o.value = '0;
    o.slot = '0;
    if (r.op == OP_INSERT) begin
      if (locate(k, n, w)) begin
        sh_val[w] = r.val;
        o.status = ST_FOUND;
        o.slot = w;
      end else if (sh_count >= CAP || sh_count * 100 >= lim * CAP) begin
        o.status = ST_FULL;
      end else begin
        o.slot = robin_place(k, LEN_W'(n), r.val);
        o.status = ST_INSERTED;
      end
    end else if (r.op == OP_REMOVE) begin
      if (locate(k, n, w)) begin
        o.value = sh_val[w];
        o.slot = w;
        o.status = ST_FOUND;
        backward_shift(w);
      end
    end else if (locate(k, n, w)) begin
      // A lookup; the unused opcode behaves the same way.
      o.value = sh_val[w];
      o.slot = w;
      o.status = ST_FOUND;
    end
    o.total = (SLOT_W+1)'(sh_count);
    return o;
  endfunction

  int unsigned gap_len;
  function automatic int unsigned random_gap();
    // Mostly no gap or a short one, now and then a long one.
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Presents one word and holds it until the block takes it.
  task automatic send_word(request_t r);
    in_valid      <= 1'b1;
    in_opcode     <= r.op;
    in_key_bytes  <= r.key;
    in_key_length <= r.len;
    in_new_value  <= r.val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    replies_due.push_back(table_reply(r));
    gap_len = random_gap();
    if (gap_len != 0) begin
      in_valid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    // Every word gives a reply, but leave a short margin before touching the register.
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sh_limit = v;
  endtask

  function automatic request_t make_request(int unsigned hit_bias);
    request_t r;
    int unsigned pick, sel;
    pick = $urandom_range(99);
    if (pick < 3) r.op = 2'd3;
    else r.op = pick < 50 ? OP_INSERT : (pick < 75 ? OP_LOOKUP : OP_REMOVE);
    r.key = {$urandom(), $urandom()};
    // Short keys collide often, which is what drives the displacement logic.
    sel = $urandom_range(9);
    if (sel < 4) r.key[63:8] = '0;
    r.len = sel < 4 ? 4'd1 : LEN_W'($urandom_range(15));
    r.val = $urandom();
    if (pool_key.size() != 0 && $urandom_range(99) < hit_bias) begin
      sel = $urandom_range(pool_key.size() - 1);
      r.key = pool_key[sel];
      r.len = pool_len[sel];
    end
    if (r.op == OP_INSERT) begin
      pool_key.push_back(r.key);
      pool_len.push_back(r.len);
      if (pool_key.size() > 300) begin
        void'(pool_key.pop_front());
        void'(pool_len.pop_front());
      end
    end
    return r;
  endfunction

  // Directed table: expected reply filled in only for rows that are obvious.
  typedef struct {
    request_t req;
    bit       known;
    reply_t   rep;
  } row_t;
  row_t plan[$];

  task automatic add_row(logic [1:0] op, logic [63:0] k, logic [3:0] n, logic [31:0] v,
                         bit known = 1'b0, status_t s = ST_ABSENT, logic [31:0] rv = '0,
                         logic [10:0] tot = '0);
    row_t w;
    w.req = '{op: op, key: k, len: n, val: v};
    w.known = known;
    w.rep = '{status: s, value: rv, slot: '0, total: tot};
    plan.push_back(w);
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
  int unsigned stall_left = 0;
  int unsigned hold_len;
  always @(posedge clk) begin
    if (!rst_n || receiver_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      hold_len = random_gap();
      if (hold_len != 0) begin
        stall_left <= hold_len - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Checker: every accepted reply word is compared with the oldest expectation.
  reply_t seen, want;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen = '{status: status_t'(out_status), value: out_read_value,
               slot: out_slot_index, total: out_entry_total};
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply word %p", seen);
      end else begin
        want = replies_due.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("reply mismatch: expected %p, got %p", want, seen);
        end
      end
    end
  end

  longint cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[robin_hood_hash_table] ERROR");
      $finish;
    end
  end

  initial begin
    reply_t pred;
    sh_count = 0;
    sh_probe = 0;
    sh_limit = LIMIT_RESET;
    for (int i = 0; i < CAP; i++) begin
      sh_used[i] = 1'b0; sh_key[i] = '0; sh_len[i] = '0; sh_val[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, extremes of key and value, every opcode,
    // out-of-range lengths and the unused opcode.
    add_row(OP_LOOKUP, 64'h0, 4'd1, 32'h0, 1'b1, ST_ABSENT, 0, 0);
    add_row(OP_REMOVE, '1, 4'd8, '1, 1'b1, ST_ABSENT, 0, 0);
    add_row(2'd3, '1, 4'd15, '0, 1'b1, ST_ABSENT, 0, 0);
    add_row(OP_INSERT, 64'h0, 4'd0, '1);
    add_row(OP_INSERT, '1, 4'd8, 32'h0);
    add_row(OP_INSERT, '1, 4'd15, 32'h1234_5678);
    add_row(OP_INSERT, 64'hFFFF_FFFF_FFFF_FF41, 4'd1, 32'hA5A5_A5A5);
    add_row(OP_LOOKUP, 64'h41, 4'd1, 32'h0);
    add_row(OP_LOOKUP, 64'h0, 4'd1, 32'h0);
    add_row(2'd3, '1, 4'd8, 32'h0);
    add_row(OP_INSERT, 64'h0807_0605_0403_0201, 4'd4, 32'h5555_AAAA);
    add_row(OP_INSERT, 64'h0403_0201, 4'd4, 32'hAAAA_5555);
    add_row(OP_LOOKUP, 64'h0403_0201, 4'd3, 32'h0);
    add_row(OP_REMOVE, 64'h41, 4'd1, 32'h0);
    add_row(OP_LOOKUP, 64'h41, 4'd1, 32'h0);
    add_row(OP_REMOVE, '1, 4'd9, 32'h0);
    add_row(OP_REMOVE, 64'h0, 4'd1, 32'h0);
    add_row(OP_REMOVE, 64'h0403_0201, 4'd4, 32'h0);
    add_row(OP_LOOKUP, 64'h0403_0201, 4'd4, 32'h0, 1'b1, ST_ABSENT, 0, 0);
    foreach (plan[i]) begin
      pred = table_reply(plan[i].req);
      if (plan[i].known && pred !== plan[i].rep) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d disagrees: %p", i, pred);
      end
      // Undo the prediction: send_word will predict again on acceptance.
      replies_due.push_back(pred);
      void'(replies_due.pop_back());
    end
    // Re-run the shadow from empty since the loop above already advanced it.
    sh_count = 0; sh_probe = 0;
    for (int i = 0; i < CAP; i++) sh_used[i] = 1'b0;
    foreach (plan[i]) send_word(plan[i].req);
    wait_drained();

    // Zero limit refuses every new key, but updates still go through; both keys sent here are new.
    write_limit(7'd0);
    send_word('{op: OP_INSERT, key: 64'h77, len: 4'd1, val: 32'h1});
    send_word('{op: OP_INSERT, key: '1, len: 4'd8, val: 32'h2});
    wait_drained();

    // Main random phase at the maximum effective limit of 100, with one long receiver hold-off.
    write_limit(7'd100);
    for (int i = 0; i < 700; i++) begin
      if (i == 200) fork
        begin
          receiver_hold = 1'b1;
          repeat (400) @(posedge clk);
          receiver_hold = 1'b0;
        end
      join_none
      send_word(make_request(55));
    end
    wait_drained();

    // Small limit so that refusals are frequent, then the largest register value.
    write_limit(7'd1);
    for (int i = 0; i < 300; i++) send_word(make_request(50));
    wait_drained();
    write_limit(7'd127);
    for (int i = 0; i < 350; i++) send_word(make_request(45));
    wait_drained();
    write_limit(7'd45);
    for (int i = 0; i < N_RANDOM - 1350; i++) send_word(make_request(60));
    wait_drained();

    repeat (50) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("[robin_hood_hash_table] OK");
    end else begin
      $display("[robin_hood_hash_table] ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+src
src/rhh_pkg.sv
src/rhh_front.sv
src/rhh_queue.sv
src/rhh_back.sv
src/robin_hood_hash_table.sv
tb/sv/robin_hood_hash_table_tb.sv
